[hdl/base58_string_decoder_assert.svh]
// Assertion macros for the base58 string decoder.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef BASE58_STRING_DECODER_ASSERT_SVH
`define BASE58_STRING_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define B58_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define B58_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define B58_ASSERT(lbl, cond, msg)
`define B58_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[hdl/b58_pkg.sv]
// Shared types, constants and character classification for the base58 decoder.
// No dependencies.
`default_nettype none

package b58_pkg;

    localparam int B58_MAX_BYTES = 48;
    localparam int B58_MAX_CHARS = 64;
    localparam int B58_RADIX     = 58;
    localparam int LZ_W          = 7;
    localparam int B58_CMD_DEPTH = 2;
    localparam int B58_CMD_PTR_W = $clog2(B58_CMD_DEPTH);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TRAILING = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] CHAR_ONE = 8'h31;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    typedef struct packed {
        logic            is_digit;
        logic            is_final;
        logic [5:0]      digit;
        logic [1:0]      status;
        logic [LZ_W-1:0] lz;
    } b58_cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = '0;
        if (c >= 8'h31 && c <= 8'h39)
        begin
            d.value = 6'(c - 8'h31);
        end
        else if (c >= 8'h41 && c <= 8'h48)
        begin
            d.value = 6'(c - 8'h41 + 8'd9);
        end
        else if (c >= 8'h4A && c <= 8'h4E)
        begin
            d.value = 6'(c - 8'h4A + 8'd17);
        end
        else if (c >= 8'h50 && c <= 8'h5A)
        begin
            d.value = 6'(c - 8'h50 + 8'd22);
        end
        else if (c >= 8'h61 && c <= 8'h6B)
        begin
            d.value = 6'(c - 8'h61 + 8'd33);
        end
        else if (c >= 8'h6D && c <= 8'h7A)
        begin
            d.value = 6'(c - 8'h6D + 8'd44);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/base58_string_decoder_if.sv]
// Valid/ready channel interfaces: character items in, decoded result items out.
// No dependencies.
`default_nettype none

interface b58_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, char_code, final_char, input ready);
    modport sink   (input valid, char_code, final_char, output ready);
endinterface

interface b58_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       end_of_result;

    modport source (output valid, data_byte, has_byte, status, end_of_result, input ready);
    modport sink   (input valid, data_byte, has_byte, status, end_of_result, output ready);
endinterface

`default_nettype wire

[hdl/b58_cmd_fifo.sv]
// Short command queue between the character scanner and the arithmetic back end.
// Depends on b58_pkg.
`default_nettype none

module b58_cmd_fifo
    import b58_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire b58_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output b58_cmd_t      head,
    output logic          empty
);

    b58_cmd_t                   slot_reg [B58_CMD_DEPTH];
    logic [B58_CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [B58_CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [B58_CMD_PTR_W:0]     count_reg;
    logic [B58_CMD_PTR_W:0]     count_next;

    assign full  = (count_reg == (B58_CMD_PTR_W+1)'(B58_CMD_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/b58_front.sv]
// Character scanner: classifies each character, tracks scan phase, leading ones
// and input errors, and queues digit and end-of-string commands. Depends on b58_pkg.
`default_nettype none

module b58_front
    import b58_pkg::*;
#(
    parameter int MAX_CHARS = B58_MAX_CHARS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    b58_in_if.sink    in_ch,
    output logic      push,
    output b58_cmd_t  push_cmd,
    input  wire logic full
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_ONES   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_TRAIL  = 4'b1000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [LZ_W-1:0] lz_reg, lz_next;
    logic [1:0]      err_reg, err_next;
    logic            accept;
    logic            ws;
    logic            dig_push;
    digit_t          dig;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign ws          = is_ws(in_ch.char_code);
    assign dig         = digit_of(in_ch.char_code);
    assign push        = accept && (dig_push || in_ch.final_char);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        lz_next    = lz_reg;
        err_next   = err_reg;
        dig_push   = 1'b0;
        if (accept && err_reg == ST_OK)
        begin
            if (cnt_reg >= CW'(MAX_CHARS))
            begin
                err_next = ST_TOO_LONG;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                unique case (phase_reg) inside
                    PH_TRAIL:
                    begin
                        if (!ws)
                        begin
                            err_next = ST_TRAILING;
                        end
                    end
                    PH_LEAD, PH_ONES, PH_DIGITS:
                    begin
                        if (ws)
                        begin
                            if (phase_reg != PH_LEAD)
                            begin
                                phase_next = PH_TRAIL;
                            end
                        end
                        else if (in_ch.char_code == CHAR_ONE && phase_reg != PH_DIGITS)
                        begin
                            phase_next = PH_ONES;
                            lz_next    = lz_reg + 1'b1;
                        end
                        else if (!dig.valid)
                        begin
                            err_next = ST_INVALID;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            dig_push   = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEAD;
                    end
                endcase
            end
        end

        push_cmd.is_digit = dig_push;
        push_cmd.is_final = in_ch.final_char;
        push_cmd.digit    = dig.value;
        push_cmd.status   = err_next;
        push_cmd.lz       = lz_next;

        if (accept && in_ch.final_char)
        begin
            phase_next = PH_LEAD;
            cnt_next   = '0;
            lz_next    = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            cnt_reg   <= '0;
            lz_reg    <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            lz_reg    <= lz_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

[hdl/b58_back.sv]
// Arithmetic back end: byte buffer memory, multiply-by-58 carry loop and result
// emission through an output register. Depends on b58_pkg and the assertion macros.
`default_nettype none
`include "base58_string_decoder_assert.svh"

module b58_back
    import b58_pkg::*;
#(
    parameter int MAX_BYTES = B58_MAX_BYTES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire b58_cmd_t cmd,
    input  wire logic     cmd_empty,
    output logic          cmd_pop,
    b58_out_if.source     out_ch
);

    localparam int AW = $clog2(MAX_BYTES);
    localparam int IW = $clog2(MAX_BYTES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_FINAL = 6'b000100,
        S_ZERO  = 6'b001000,
        S_RD    = 6'b010000,
        S_WR    = 6'b100000
    } back_state_t;

    back_state_t     state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   idx_inc;
    logic [IW-1:0]   used_reg, used_next;
    logic [IW-1:0]   used_dec;
    logic [5:0]      carry_reg, carry_next;
    logic            ovf_reg, ovf_next;
    logic            pend_final_reg, pend_final_next;
    logic [1:0]      st_reg, st_next;
    logic [LZ_W-1:0] lz_reg, lz_next;

    logic [7:0]      mem [MAX_BYTES];
    logic [7:0]      rdata_reg;
    logic            re;
    logic [AW-1:0]   raddr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;

    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_has_reg;
    logic [1:0]      out_st_reg;
    logic            out_last_reg;
    logic            out_free;
    logic            load;
    logic [7:0]      ld_byte;
    logic            ld_has;
    logic [1:0]      ld_st;
    logic            ld_last;

    logic [7:0]      src;
    logic [13:0]     prod;
    logic            mul_go;
    logic            single_item;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign idx_inc  = idx_reg + 1'b1;
    assign used_dec = used_reg - 1'b1;
    assign src      = (idx_reg < used_reg) ? rdata_reg : 8'd0;
    assign prod     = 14'(src) * 14'(B58_RADIX) + 14'(carry_reg);
    assign mul_go   = ((carry_reg != '0) || (idx_reg < used_reg)) && (idx_reg < IW'(MAX_BYTES));
    assign single_item = ovf_reg || (st_reg != ST_OK) || (lz_reg == '0 && used_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        carry_next      = carry_reg;
        ovf_next        = ovf_reg;
        pend_final_next = pend_final_reg;
        st_next         = st_reg;
        lz_next         = lz_reg;
        cmd_pop         = 1'b0;
        re              = 1'b0;
        raddr           = '0;
        we              = 1'b0;
        waddr           = idx_reg[AW-1:0];
        wdata           = prod[7:0];
        load            = 1'b0;
        ld_byte         = 8'd0;
        ld_has          = 1'b0;
        ld_st           = ST_OK;
        ld_last         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop         = 1'b1;
                    pend_final_next = cmd.is_final;
                    st_next         = cmd.status;
                    lz_next         = cmd.lz;
                    if (cmd.is_digit && !ovf_reg)
                    begin
                        carry_next = cmd.digit;
                        idx_next   = '0;
                        re         = 1'b1;
                        state_next = S_MUL;
                    end
                    else if (cmd.is_final)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_go)
                begin
                    we         = 1'b1;
                    carry_next = prod[13:8];
                    idx_next   = idx_inc;
                    re         = 1'b1;
                    raddr      = idx_inc[AW-1:0];
                end
                else
                begin
                    if (carry_reg != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        used_next = idx_reg;
                    end
                    state_next = pend_final_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (single_item)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        ld_st      = ovf_reg ? ST_TOO_LONG : st_reg;
                        ld_last    = 1'b1;
                        used_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else if (lz_reg != '0)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    idx_next   = used_dec;
                    state_next = S_RD;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_has  = 1'b1;
                    ld_last = (lz_reg == LZ_W'(1)) && (used_reg == '0);
                    lz_next = lz_reg - 1'b1;
                    if (lz_reg == LZ_W'(1))
                    begin
                        if (used_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = used_dec;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                re         = 1'b1;
                raddr      = idx_reg[AW-1:0];
                state_next = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_byte = rdata_reg;
                    ld_has  = 1'b1;
                    ld_last = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        used_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            used_reg       <= '0;
            carry_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_final_reg <= 1'b0;
            st_reg         <= ST_OK;
            lz_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            carry_reg      <= carry_next;
            ovf_reg        <= ovf_next;
            pend_final_reg <= pend_final_next;
            st_reg         <= st_next;
            lz_reg         <= lz_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= ld_byte;
            out_has_reg  <= ld_has;
            out_st_reg   <= ld_st;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.data_byte     = out_byte_reg;
    assign out_ch.has_byte      = out_has_reg;
    assign out_ch.status        = out_st_reg;
    assign out_ch.end_of_result = out_last_reg;

    `B58_ASSERT(a_used_bound, used_reg <= IW'(MAX_BYTES), "fill count beyond buffer size")
    `B58_ASSERT_IMPL(a_carry_bound, state_reg == S_MUL, carry_reg < 6'd58, "carry out of range")
    `B58_ASSERT_IMPL(a_status_item_last, out_valid_reg && !out_has_reg, out_last_reg,
                     "status item not marked last")
    `B58_ASSERT_IMPL(a_byte_item_ok, out_valid_reg && out_has_reg, out_st_reg == ST_OK,
                     "byte item with error status")
    `B58_ASSERT_IMPL(a_pop_idle, cmd_pop, state_reg == S_IDLE && !cmd_empty,
                     "command taken while busy")

endmodule

`default_nettype wire

[hdl/base58_string_decoder.sv]
// Base58 text decoder top level: scanner, command queue and arithmetic back end.
// Depends on b58_pkg, the channel interfaces, b58_front, b58_cmd_fifo, b58_back.
//
//   channel  dir  payload                                         accept
//   in_ch    in   char_code[7:0] final_char                       valid && ready
//   out_ch   out  data_byte[7:0] has_byte status[1:0] end_of_result valid && ready
//
// A digit makes the back end multiply the buffer by 58 and add the digit, one buffer
// byte per cycle, through separate read and write ports of the buffer memory. The
// final character then emits a status item alone on error or empty input, else one
// zero byte per leading zero and each significant byte, read from memory and then
// sent; a held result stalls them. A two-entry command queue lets the scanner run
// ahead. Reset clears control state at once; buffer bytes past the fill count read as zero.
`default_nettype none

module base58_string_decoder
    import b58_pkg::*;
#(
    parameter int MAX_BYTES = B58_MAX_BYTES,
    parameter int MAX_CHARS = B58_MAX_CHARS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    b58_in_if.sink    in_ch,
    b58_out_if.source out_ch
);

    b58_cmd_t push_cmd;
    b58_cmd_t head;
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;

    b58_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    b58_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    b58_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
